// ===== hw/rtl/running_dft_field_accumulator_unit_macros.svh =====
// Assertion macros shared by the running DFT accumulator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RUNNING_DFT_FIELD_ACCUMULATOR_UNIT_MACROS_SVH
`define RUNNING_DFT_FIELD_ACCUMULATOR_UNIT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define RDFA_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RDFA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RDFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rdfa_pkg.sv =====
// Package for the running DFT accumulator: field widths, codes, shared types
// and the quarter-wave sine table function. No dependencies.
package rdfa_pkg;

  localparam int NUM_CELLS_DEF       = 1024;
  localparam int MAX_FREQS_DEF       = 4;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int ACTION_W = 2;
  localparam int CELL_W   = 10;
  localparam int VALUE_W  = 24;
  localparam int TIME_W   = 32;
  localparam int ACC_W    = 48;
  localparam int SLOT_W   = 2;
  localparam int STEP_W   = 32;
  localparam int NFREQ_W  = 3;
  localparam int SCALE_W  = 16;
  localparam int TRIG_W   = 18;
  localparam int SINE_W   = 17;
  localparam int NUM_STEPS = 4;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACCUM = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_FREQ_STEP_0  = 3'd0,
    REG_FREQ_STEP_1  = 3'd1,
    REG_FREQ_STEP_2  = 3'd2,
    REG_FREQ_STEP_3  = 3'd3,
    REG_NUM_FREQS    = 3'd4,
    REG_WEIGHT_SCALE = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PHASE,
    ST_TABLE,
    ST_MUL_V,
    ST_MUL_S,
    ST_ROUND,
    ST_WRITE,
    ST_RD_ADDR,
    ST_RD_PUT,
    ST_CLEAR
  } back_state_t;

  typedef struct packed {
    action_t                    op;
    logic                       cell_ok;
    logic [CELL_W-1:0]          cell_idx;
    logic signed [VALUE_W-1:0]  value;
    logic [TIME_W-1:0]          stime;
    logic [SLOT_W-1:0]          last_idx;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic sweeping;
  } back_ctl_t;

  // Quarter-wave sine entry, unsigned Q1.16, from a fixed-point series.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * 64'(k)) >> bits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    return SINE_W'((s + 64'd8192) >> 14);
  endfunction

endpackage

// ===== hw/rtl/rdfa_if.sv =====
// Channel interfaces of the running DFT accumulator: request words in and
// result words out. Depends on rdfa_pkg.
interface rdfa_req_if;
  import rdfa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [CELL_W-1:0]         cell_index;
  logic signed [VALUE_W-1:0] field_value;
  logic [TIME_W-1:0]         sample_time;
  modport source (output valid, action, cell_index, field_value, sample_time,
                  input ready);
  modport sink (input valid, action, cell_index, field_value, sample_time,
                output ready);
endinterface

interface rdfa_rsp_if;
  import rdfa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SLOT_W-1:0]       freq_index;
  logic signed [ACC_W-1:0] acc_real;
  logic signed [ACC_W-1:0] acc_imag;
  logic                    last;
  modport source (output valid, freq_index, acc_real, acc_imag, last, input ready);
  modport sink (input valid, freq_index, acc_real, acc_imag, last, output ready);
endinterface

// ===== hw/rtl/rdfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies beyond rdfa_pkg defaults.
module rdfa_ram #(
  parameter int WIDTH = 2 * rdfa_pkg::ACC_W,
  parameter int DEPTH = rdfa_pkg::NUM_CELLS_DEF * rdfa_pkg::MAX_FREQS_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/rdfa_front.sv =====
// Front end: accepts request words, classifies them and holds them in a
// two-entry queue for the back end. Depends on rdfa_pkg and rdfa_if.
`include "running_dft_field_accumulator_unit_macros.svh"
module rdfa_front #(
  parameter int NUM_CELLS = rdfa_pkg::NUM_CELLS_DEF,
  parameter int MAX_FREQS = rdfa_pkg::MAX_FREQS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  rdfa_req_if.sink                     req,
  input  logic [rdfa_pkg::NFREQ_W-1:0] num_freqs,
  input  rdfa_pkg::back_ctl_t          ctl,
  output rdfa_pkg::q_head_t            head
);
  import rdfa_pkg::*;

  item_t             q [2];
  logic              wp;
  logic              rp;
  logic [1:0]        count;
  action_t           act;
  logic              cell_ok;
  logic              keep;
  logic              push;
  logic              pop;
  logic [NFREQ_W-1:0] eff;
  item_t             cls;

  always_comb begin
    act     = action_t'(req.action);
    cell_ok = {7'd0, req.cell_index} < 17'(NUM_CELLS);
    keep    = (act == ACT_READ) || (((act == ACT_ACCUM) || (act == ACT_CLEAR)) && cell_ok);
    if (num_freqs == '0) begin
      eff = NFREQ_W'(1);
    end else if (num_freqs > NFREQ_W'(MAX_FREQS)) begin
      eff = NFREQ_W'(MAX_FREQS);
    end else begin
      eff = num_freqs;
    end
    cls.op       = act;
    cls.cell_ok  = cell_ok;
    cls.cell_idx = req.cell_index;
    cls.value    = req.field_value;
    cls.stime    = req.sample_time;
    cls.last_idx = (act == ACT_CLEAR) ? SLOT_W'(MAX_FREQS - 1) : SLOT_W'(eff - NFREQ_W'(1));
  end

  assign req.ready  = (count != 2'd2) && !ctl.sweeping;
  assign push       = req.valid && req.ready && keep;
  assign pop        = ctl.pop;
  assign head.valid = (count != 2'd0);
  assign head.item  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
  end

  `RDFA_ASSERT_HOLDS(a_count_bound, clk, rst, count <= 2'd2, "queue count out of range")
  `RDFA_ASSERT_IMPLIES(a_no_take_sweep, clk, rst, ctl.sweeping, !req.ready, "word taken during clearing pass")
  `RDFA_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + 2'd1, "queue count did not grow")
endmodule

// ===== hw/rtl/rdfa_back.sv =====
// Back end: clearing pass, per-slot phase, table lookup, weighted
// multiply-accumulate with saturation, bin reads and clears. Depends on
// rdfa_pkg, rdfa_if and rdfa_ram.
`include "running_dft_field_accumulator_unit_macros.svh"
module rdfa_back #(
  parameter int NUM_CELLS       = rdfa_pkg::NUM_CELLS_DEF,
  parameter int MAX_FREQS       = rdfa_pkg::MAX_FREQS_DEF,
  parameter int SINE_TABLE_BITS = rdfa_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rdfa_pkg::q_head_t            head,
  output rdfa_pkg::back_ctl_t          ctl,
  input  logic [rdfa_pkg::STEP_W-1:0]  freq_step [rdfa_pkg::NUM_STEPS],
  input  logic [rdfa_pkg::SCALE_W-1:0] weight_scale,
  rdfa_rsp_if.source                   rsp
);
  import rdfa_pkg::*;

  localparam int DEPTH   = NUM_CELLS * MAX_FREQS;
  localparam int AW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int TABLE_N = 1 << SINE_TABLE_BITS;
  localparam int TW      = SINE_TABLE_BITS + 1;
  localparam int PROD_W  = VALUE_W + TRIG_W;
  localparam int Q_W     = PROD_W + SCALE_W + 1;
  localparam int TERM_W  = 46;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  back_state_t state;
  back_state_t state_next;
  item_t       cur;
  logic [SLOT_W-1:0] slot;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     sweep_addr;
  logic [STEP_W-1:0] phase;
  logic [SINE_W-1:0] lo;
  logic [SINE_W-1:0] hi;
  logic signed [ACC_W-1:0] old_re;
  logic signed [ACC_W-1:0] old_im;
  logic signed [PROD_W-1:0] pc;
  logic signed [PROD_W-1:0] ps;
  logic signed [Q_W-1:0]    qc;
  logic signed [Q_W-1:0]    qs;
  logic signed [TERM_W-1:0] tc;
  logic signed [TERM_W-1:0] ts;
  logic signed [TRIG_W-1:0] c_sel;
  logic signed [TRIG_W-1:0] ns_sel;
  logic signed [TRIG_W-1:0] lo_s;
  logic signed [TRIG_W-1:0] hi_s;
  logic [SINE_W-1:0] sine_rom [TABLE_N+1];
  logic [TW-1:0]     kk;
  logic [CELL_W+2:0] base_full;
  logic signed [ACC_W:0] sum_re;
  logic signed [ACC_W:0] sum_im;
  logic signed [ACC_W-1:0] sat_re;
  logic signed [ACC_W-1:0] sat_im;
  logic [Q_W-1:0]  mag_c;
  logic [Q_W-1:0]  mag_s;
  logic [TERM_W-2:0] r_c;
  logic [TERM_W-2:0] r_s;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [2*ACC_W-1:0] wdata;
  logic [2*ACC_W-1:0] rdata;
  logic            out_load;
  logic            out_free;
  logic            step_slot;
  logic            out_valid;

  for (genvar k = 0; k <= TABLE_N; k++) begin : g_rom
    localparam logic [SINE_W-1:0] ENTRY = sine_entry(k, SINE_TABLE_BITS);
    assign sine_rom[k] = ENTRY;
  end

  rdfa_ram #(.WIDTH(2 * ACC_W), .DEPTH(DEPTH)) u_bins (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  assign kk        = {1'b0, phase[29 -: SINE_TABLE_BITS]};
  assign base_full = {3'd0, head.item.cell_idx} * (CELL_W+3)'(MAX_FREQS);
  assign out_free  = !out_valid || rsp.ready;
  assign lo_s      = $signed({1'b0, lo});
  assign hi_s      = $signed({1'b0, hi});

  always_comb begin
    case (phase[31:30])
      2'd0:    begin c_sel = hi_s;  ns_sel = -lo_s; end
      2'd1:    begin c_sel = -lo_s; ns_sel = -hi_s; end
      2'd2:    begin c_sel = -hi_s; ns_sel = lo_s;  end
      default: begin c_sel = lo_s;  ns_sel = hi_s;  end
    endcase
  end

  always_comb begin
    mag_c = qc[Q_W-1] ? Q_W'(-qc) : Q_W'(qc);
    mag_s = qs[Q_W-1] ? Q_W'(-qs) : Q_W'(qs);
    r_c   = (TERM_W-1)'((mag_c + Q_W'(8192)) >> 14);
    r_s   = (TERM_W-1)'((mag_s + Q_W'(8192)) >> 14);
    sum_re = $signed({old_re[ACC_W-1], old_re}) + (ACC_W+1)'(tc);
    sum_im = $signed({old_im[ACC_W-1], old_im}) + (ACC_W+1)'(ts);
    if (sum_re[ACC_W] != sum_re[ACC_W-1]) begin
      sat_re = sum_re[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_re = sum_re[ACC_W-1:0];
    end
    if (sum_im[ACC_W] != sum_im[ACC_W-1]) begin
      sat_im = sum_im[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_im = sum_im[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    we           = 1'b0;
    waddr        = addr;
    wdata        = '0;
    out_load     = 1'b0;
    step_slot    = 1'b0;
    ctl.pop      = 1'b0;
    ctl.sweeping = (state == ST_SWEEP);
    case (state)
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_addr;
        if (sweep_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          ctl.pop = 1'b1;
          case (head.item.op)
            ACT_ACCUM: state_next = ST_PHASE;
            ACT_READ:  state_next = ST_RD_ADDR;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_PHASE: state_next = ST_TABLE;
      ST_TABLE: state_next = ST_MUL_V;
      ST_MUL_V: state_next = ST_MUL_S;
      ST_MUL_S: state_next = ST_ROUND;
      ST_ROUND: state_next = ST_WRITE;
      ST_WRITE: begin
        we    = 1'b1;
        wdata = {sat_re, sat_im};
        step_slot = 1'b1;
        state_next = (slot == cur.last_idx) ? ST_IDLE : ST_PHASE;
      end
      ST_RD_ADDR: state_next = ST_RD_PUT;
      ST_RD_PUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          step_slot = 1'b1;
          state_next = (slot == cur.last_idx) ? ST_IDLE : ST_RD_ADDR;
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        step_slot = 1'b1;
        state_next = (slot == cur.last_idx) ? ST_IDLE : ST_CLEAR;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      slot       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_SWEEP) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (ctl.pop) begin
        slot <= '0;
      end else if (step_slot) begin
        slot <= slot + SLOT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur  <= head.item;
      addr <= AW'(base_full);
    end else if (step_slot) begin
      addr <= addr + AW'(1);
    end
    case (state)
      ST_PHASE: phase <= STEP_W'(freq_step[slot] * cur.stime);
      ST_TABLE: begin
        lo     <= sine_rom[kk];
        hi     <= sine_rom[TW'(TABLE_N) - kk];
        old_re <= rdata[2*ACC_W-1:ACC_W];
        old_im <= rdata[ACC_W-1:0];
      end
      ST_MUL_V: begin
        pc <= cur.value * c_sel;
        ps <= cur.value * ns_sel;
      end
      ST_MUL_S: begin
        qc <= pc * $signed({1'b0, weight_scale});
        qs <= ps * $signed({1'b0, weight_scale});
      end
      ST_ROUND: begin
        tc <= qc[Q_W-1] ? -$signed({1'b0, r_c}) : $signed({1'b0, r_c});
        ts <= qs[Q_W-1] ? -$signed({1'b0, r_s}) : $signed({1'b0, r_s});
      end
      default: begin
      end
    endcase
    if (out_load) begin
      rsp.freq_index <= slot;
      rsp.acc_real   <= cur.cell_ok ? rdata[2*ACC_W-1:ACC_W] : '0;
      rsp.acc_imag   <= cur.cell_ok ? rdata[ACC_W-1:0] : '0;
      rsp.last       <= (slot == cur.last_idx);
    end
  end

  assign rsp.valid = out_valid;

  `RDFA_ASSERT_IMPLIES(a_waddr_range, clk, rst, we, waddr <= AW'(DEPTH - 1), "bin write beyond memory")
  `RDFA_ASSERT_IMPLIES(a_slot_bound, clk, rst, (state != ST_IDLE) && (state != ST_SWEEP), slot <= cur.last_idx, "slot beyond last")
  `RDFA_ASSERT_IMPLIES(a_write_is_accum, clk, rst, state == ST_WRITE, cur.op == ACT_ACCUM, "accumulate write for other op")
endmodule

// ===== hw/rtl/running_dft_field_accumulator_unit.sv =====
// Top level of the running DFT accumulator: APB register file, front end
// and back end. Depends on rdfa_pkg, rdfa_if, rdfa_front and rdfa_back.
//
// After reset the block zeroes its bin memory, one entry per cycle, for all
// NUM_CELLS*MAX_FREQS entries (4096 by default) and takes no word in that time.
// Words then queue in a two-entry buffer and run one at a time on one bin
// memory and one multiply chain: an accumulate runs phase, table, multiply,
// scale, round and write for each of N active slots, a read puts out each
// slot, waiting while results are untaken; a clear zeroes all MAX_FREQS slots.
module running_dft_field_accumulator_unit #(
  parameter int NUM_CELLS       = rdfa_pkg::NUM_CELLS_DEF,
  parameter int MAX_FREQS       = rdfa_pkg::MAX_FREQS_DEF,
  parameter int SINE_TABLE_BITS = rdfa_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  rdfa_req_if.sink                     req,
  rdfa_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rdfa_pkg::PADDR_W-1:0] paddr,
  input  logic [rdfa_pkg::PDATA_W-1:0] pwdata,
  output logic [rdfa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import rdfa_pkg::*;

  logic [STEP_W-1:0]  freq_step [NUM_STEPS];
  logic [NFREQ_W-1:0] num_freqs;
  logic [SCALE_W-1:0] weight_scale;
  reg_index_t         reg_sel;
  logic               wr_en;
  back_ctl_t          ctl;
  q_head_t            head;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STEPS; i++) begin
        freq_step[i] <= '0;
      end
      num_freqs    <= NFREQ_W'(1);
      weight_scale <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FREQ_STEP_0:  freq_step[0] <= pwdata;
        REG_FREQ_STEP_1:  freq_step[1] <= pwdata;
        REG_FREQ_STEP_2:  freq_step[2] <= pwdata;
        REG_FREQ_STEP_3:  freq_step[3] <= pwdata;
        REG_NUM_FREQS:    num_freqs <= pwdata[NFREQ_W-1:0];
        REG_WEIGHT_SCALE: weight_scale <= pwdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FREQ_STEP_0:  prdata = freq_step[0];
      REG_FREQ_STEP_1:  prdata = freq_step[1];
      REG_FREQ_STEP_2:  prdata = freq_step[2];
      REG_FREQ_STEP_3:  prdata = freq_step[3];
      REG_NUM_FREQS:    prdata = PDATA_W'(num_freqs);
      REG_WEIGHT_SCALE: prdata = PDATA_W'(weight_scale);
      default:          prdata = '0;
    endcase
  end

  rdfa_front #(.NUM_CELLS(NUM_CELLS), .MAX_FREQS(MAX_FREQS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .num_freqs(num_freqs),
    .ctl      (ctl),
    .head     (head)
  );

  rdfa_back #(
    .NUM_CELLS      (NUM_CELLS),
    .MAX_FREQS      (MAX_FREQS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .ctl         (ctl),
    .freq_step   (freq_step),
    .weight_scale(weight_scale),
    .rsp         (rsp)
  );
endmodule
